// ===== hw/rtl/kat_pkg.sv =====
// Shared types, codes and helpers for the keyed alias table.
// No dependencies; every module of the block uses this package, the interfaces do not.
package kat_pkg;

    localparam int ENTRIES_DEF  = 16;
    localparam int MAX_TEXT_DEF = 16;
    localparam int QUEUE_DEPTH  = 2;

    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_MISS   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_SET    = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_REJECT = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] key;
        logic [31:0] stamp;
    } cmd_hdr_t;

    localparam int HDR_W = $bits(cmd_hdr_t);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TRIM,
        S_SCAN,
        S_DISPATCH,
        S_COPY,
        S_META,
        S_RESULT,
        S_LREAD,
        S_LEMIT
    } bk_state_t;

    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_CODE = 8'h80;

    function automatic logic is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_CODE;
    endfunction

endpackage

// ===== hw/rtl/kat_in_if.sv =====
// Request channel of the keyed alias table: valid/ready plus one input item.
// Depends on nothing.
interface kat_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] node_id;
    logic [7:0]  text_byte;
    logic        last_byte;
    logic [31:0] now_time;

    modport source (output valid, opcode, node_id, text_byte, last_byte, now_time,
                    input ready);
    modport sink   (input valid, opcode, node_id, text_byte, last_byte, now_time,
                    output ready);
endinterface

// ===== hw/rtl/kat_out_if.sv =====
// Response channel of the keyed alias table: valid/ready plus one result item.
// Depends on nothing.
interface kat_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  out_byte;
    logic [4:0]  alias_length;
    logic        last_result;

    modport source (output valid, status, out_byte, alias_length, last_result,
                    input ready);
    modport sink   (input valid, status, out_byte, alias_length, last_result,
                    output ready);
endinterface

// ===== hw/rtl/kat_queue.sv =====
// Small command FIFO between the front and back parts of the alias table.
// Depends on kat_pkg for the default depth.
module kat_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = kat_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, rptr_reg;
    logic [PW:0]      fill_reg;

    assign full      = (fill_reg == (PW+1)'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign pop_data  = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("command queue overrun");
    pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("command queue underrun");
    fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= (PW+1)'(DEPTH))
        else $error("command queue fill count out of range");
endmodule

// ===== hw/rtl/kat_front.sv =====
// Front part of the alias table: takes requests, stages set bytes and queues
// classified commands. Depends on kat_pkg and kat_in_if.
module kat_front #(
    parameter int MAX_TEXT = kat_pkg::MAX_TEXT_DEF
) (
    input  logic clk,
    input  logic rst_n,
    kat_in_if.sink cmd,
    output logic push,
    output logic [kat_pkg::HDR_W+$clog2(MAX_TEXT+2)+8+8*MAX_TEXT-1:0] push_data,
    input  logic full
);
    import kat_pkg::*;

    localparam int CW  = $clog2(MAX_TEXT + 2);
    localparam int TXW = 8 * MAX_TEXT;

    logic [7:0]    txt_reg [MAX_TEXT];
    logic [7:0]    txt_next [MAX_TEXT];
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0]    ovf_reg, ovf_next;
    logic [TXW-1:0] txt_flat;
    logic          is_set, ends_item, accept;
    cmd_hdr_t      hdr;

    assign is_set    = (cmd.opcode == OP_SET);
    assign ends_item = is_set ? cmd.last_byte
                              : (cmd.opcode == OP_CLEAR || cmd.opcode == OP_LOOKUP);
    assign cmd.ready = !ends_item || !full;
    assign accept    = cmd.valid && cmd.ready;
    assign push      = accept && ends_item;

    // staging after this byte
    always_comb
    begin
        for (int i = 0; i < MAX_TEXT; i++)
        begin
            txt_next[i] = (cnt_reg == CW'(i)) ? cmd.text_byte : txt_reg[i];
            txt_flat[8*i +: 8] = txt_next[i];
        end
        cnt_next = (cnt_reg <= CW'(MAX_TEXT)) ? cnt_reg + 1'b1 : cnt_reg;
        ovf_next = (cnt_reg == CW'(MAX_TEXT)) ? cmd.text_byte : ovf_reg;
    end

    always_comb
    begin
        hdr.key   = cmd.node_id;
        hdr.stamp = cmd.now_time;
        case (cmd.opcode)
            OP_SET:    hdr.kind = CMD_SET;
            OP_CLEAR:  hdr.kind = CMD_CLEAR;
            OP_LOOKUP: hdr.kind = CMD_LOOKUP;
            default:   hdr.kind = CMD_REJECT;
        endcase
        if (cmd.node_id == '0)
        begin
            hdr.kind = CMD_REJECT;
        end
    end

    assign push_data = {hdr, cnt_next, ovf_next, txt_flat};

    always_ff @(posedge clk)
    begin
        if (accept && is_set && !cmd.last_byte)
        begin
            for (int i = 0; i < MAX_TEXT; i++)
            begin
                txt_reg[i] <= txt_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ovf_reg <= '0;
        end
        else if (accept && is_set)
        begin
            cnt_reg <= cmd.last_byte ? '0 : cnt_next;
            ovf_reg <= ovf_next;
        end
    end
endmodule

// ===== hw/rtl/kat_back.sv =====
// Back part of the alias table: trims, scans the entries, commits, clears and
// streams lookups. Depends on kat_pkg and kat_out_if.
module kat_back #(
    parameter int ENTRIES  = kat_pkg::ENTRIES_DEF,
    parameter int MAX_TEXT = kat_pkg::MAX_TEXT_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  logic [kat_pkg::HDR_W+$clog2(MAX_TEXT+2)+8+8*MAX_TEXT-1:0] q_data,
    output logic pop,
    kat_out_if.source rsp
);
    import kat_pkg::*;

    localparam int CW  = $clog2(MAX_TEXT + 2);
    localparam int LW  = $clog2(MAX_TEXT + 1);
    localparam int KW  = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
    localparam int IW  = $clog2(ENTRIES);
    localparam int TXW = 8 * MAX_TEXT;
    localparam int AW  = $clog2(ENTRIES * MAX_TEXT);

    // queue fields
    cmd_hdr_t      q_hdr;
    logic [CW-1:0] q_cnt;
    logic [7:0]    q_ovf;
    assign q_hdr = q_data[TXW+8+CW +: HDR_W];
    assign q_cnt = q_data[TXW+8 +: CW];
    assign q_ovf = q_data[TXW +: 8];

    // memories
    logic [31:0]   key_mem   [ENTRIES];
    logic [31:0]   stamp_mem [ENTRIES];
    logic [LW-1:0] len_mem   [ENTRIES];
    logic [7:0]    text_mem  [ENTRIES*MAX_TEXT];
    logic [31:0]   key_rd, stamp_rd;
    logic [LW-1:0] len_rd;
    logic [7:0]    text_rd;

    bk_state_t      state_reg, state_next;
    cmd_hdr_t       hdr_reg;
    logic [TXW-1:0] txt_reg;
    logic [LW-1:0]  len_reg, k_reg, flen_reg;
    logic           trim_reg;
    logic [IW:0]    scan_reg;
    logic           found_reg, free_reg, have_old_reg;
    logic [IW-1:0]  fidx_reg, freeidx_reg, oidx_reg, tgt_reg;
    logic [31:0]    old_stamp_reg;
    status_t        res_st_reg;
    logic [ENTRIES-1:0] valid_reg;

    logic           out_valid_reg, out_last_reg;
    logic [1:0]     out_status_reg;
    logic [7:0]     out_byte_reg;
    logic [4:0]     out_len_reg;

    logic           out_free, load_out, text_we, meta_we, trim_step;
    logic [IW-1:0]  eval_ix;
    logic [AW-1:0]  text_addr;
    logic [7:0]     trim_byte;
    logic [LW+4:0]  flen_ext;
    logic           q_trim;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign eval_ix   = IW'(scan_reg - 1'b1);
    assign trim_byte = txt_reg[{len_reg[KW-1:0], 3'b000} +: 8];
    assign trim_step = (len_reg != '0) && is_cont(trim_byte);
    assign q_trim    = (q_cnt > CW'(MAX_TEXT)) && is_cont(q_ovf);
    assign flen_ext  = {5'b0, flen_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_hdr.kind == CMD_REJECT)
                        state_next = S_RESULT;
                    else if (q_hdr.kind == CMD_SET && q_trim)
                        state_next = S_TRIM;
                    else
                        state_next = S_SCAN;
                end
            end
            S_TRIM:
            begin
                if (!trim_reg && !trim_step)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_reg == (IW+1)'(ENTRIES))
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                case (hdr_reg.kind)
                    CMD_SET:
                        state_next = (len_reg == '0) ? S_META : S_COPY;
                    CMD_LOOKUP:
                        state_next = (found_reg && flen_reg != '0) ? S_LREAD : S_RESULT;
                    default:
                        state_next = S_RESULT;
                endcase
            end
            S_COPY:
            begin
                if (k_reg == len_reg - 1'b1)
                    state_next = S_META;
            end
            S_META:
                state_next = S_RESULT;
            S_RESULT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            S_LREAD:
                state_next = S_LEMIT;
            S_LEMIT:
            begin
                if (out_free)
                    state_next = (k_reg == flen_reg - 1'b1) ? S_IDLE : S_LREAD;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        pop       = 1'b0;
        load_out  = 1'b0;
        text_we   = 1'b0;
        meta_we   = 1'b0;
        text_addr = AW'(tgt_reg) * AW'(MAX_TEXT) + AW'(k_reg);
        case (state_reg)
            S_IDLE:   pop = q_valid;
            S_COPY:   text_we = 1'b1;
            S_META:   meta_we = 1'b1;
            S_RESULT: load_out = out_free;
            S_LREAD:  text_addr = AW'(fidx_reg) * AW'(MAX_TEXT) + AW'(k_reg);
            S_LEMIT:  load_out = out_free;
            default:  pop = 1'b0;
        endcase
    end

    // entry memories, registered reads
    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            key_mem[tgt_reg]   <= hdr_reg.key;
            stamp_mem[tgt_reg] <= hdr_reg.stamp;
            len_mem[tgt_reg]   <= len_reg;
        end
        key_rd   <= key_mem[scan_reg[IW-1:0]];
        stamp_rd <= stamp_mem[scan_reg[IW-1:0]];
        len_rd   <= len_mem[scan_reg[IW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (text_we)
        begin
            text_mem[text_addr] <= txt_reg[{k_reg[KW-1:0], 3'b000} +: 8];
        end
        if (state_reg == S_LREAD)
        begin
            text_rd <= text_mem[text_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hdr_reg       <= '0;
            txt_reg       <= '0;
            len_reg       <= '0;
            k_reg         <= '0;
            flen_reg      <= '0;
            trim_reg      <= 1'b0;
            scan_reg      <= '0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            have_old_reg  <= 1'b0;
            fidx_reg      <= '0;
            freeidx_reg   <= '0;
            oidx_reg      <= '0;
            tgt_reg       <= '0;
            old_stamp_reg <= '0;
            res_st_reg    <= ST_OK;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        hdr_reg      <= q_hdr;
                        txt_reg      <= q_data[TXW-1:0];
                        len_reg      <= (q_cnt > CW'(MAX_TEXT)) ? LW'(MAX_TEXT)
                                                                : q_cnt[LW-1:0];
                        trim_reg     <= q_trim;
                        scan_reg     <= '0;
                        found_reg    <= 1'b0;
                        free_reg     <= 1'b0;
                        have_old_reg <= 1'b0;
                        res_st_reg   <= (q_hdr.kind == CMD_REJECT) ? ST_REJECT : ST_OK;
                    end
                end
                S_TRIM:
                begin
                    if (trim_reg)
                    begin
                        len_reg  <= len_reg - 1'b1;
                        trim_reg <= 1'b0;
                    end
                    else if (trim_step)
                    begin
                        len_reg <= len_reg - 1'b1;
                    end
                end
                S_SCAN:
                begin
                    scan_reg <= scan_reg + 1'b1;
                    if (scan_reg != '0)
                    begin
                        if (valid_reg[eval_ix] && key_rd == hdr_reg.key && !found_reg)
                        begin
                            found_reg <= 1'b1;
                            fidx_reg  <= eval_ix;
                            flen_reg  <= len_rd;
                        end
                        if (!valid_reg[eval_ix] && !free_reg)
                        begin
                            free_reg    <= 1'b1;
                            freeidx_reg <= eval_ix;
                        end
                        if (valid_reg[eval_ix] && (!have_old_reg || stamp_rd < old_stamp_reg))
                        begin
                            have_old_reg  <= 1'b1;
                            old_stamp_reg <= stamp_rd;
                            oidx_reg      <= eval_ix;
                        end
                    end
                end
                S_DISPATCH:
                begin
                    k_reg   <= '0;
                    tgt_reg <= found_reg ? fidx_reg : (free_reg ? freeidx_reg : oidx_reg);
                    if (hdr_reg.kind == CMD_LOOKUP && !found_reg)
                        res_st_reg <= ST_MISS;
                    if (hdr_reg.kind == CMD_CLEAR && found_reg)
                        valid_reg[fidx_reg] <= 1'b0;
                end
                S_COPY:
                    k_reg <= k_reg + 1'b1;
                S_META:
                    valid_reg[tgt_reg] <= 1'b1;
                S_LEMIT:
                begin
                    if (out_free)
                        k_reg <= k_reg + 1'b1;
                end
                default:
                    k_reg <= k_reg;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_byte_reg   <= '0;
            out_len_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
            if (state_reg == S_LEMIT)
            begin
                out_status_reg <= ST_OK;
                out_byte_reg   <= text_rd;
                out_len_reg    <= flen_ext[4:0];
                out_last_reg   <= (k_reg == flen_reg - 1'b1);
            end
            else
            begin
                out_status_reg <= res_st_reg;
                out_byte_reg   <= '0;
                out_len_reg    <= '0;
                out_last_reg   <= 1'b1;
            end
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.out_byte     = out_byte_reg;
    assign rsp.alias_length = out_len_reg;
    assign rsp.last_result  = out_last_reg;

    copy_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_COPY |-> k_reg < len_reg)
        else $error("text copy ran past the committed length");
    found_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DISPATCH && found_reg |-> valid_reg[fidx_reg])
        else $error("matched entry is not valid");
    stream_has_text: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LEMIT |-> found_reg && flen_reg != '0 && k_reg < flen_reg)
        else $error("lookup stream without stored text");
    commit_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_META |=> valid_reg[$past(tgt_reg)])
        else $error("committed entry not marked valid");
endmodule

// ===== hw/rtl/keyed_alias_table_oldest_evict.sv =====
// Keyed alias table, top level: front part, command queue and back part.
// Depends on kat_pkg, kat_in_if, kat_out_if, kat_front, kat_queue, kat_back.
//
// A table of ENTRIES slots, each holding a node id, a write time and up to
// MAX_TEXT text bytes. Opcode set streams text one byte per transfer; the
// transfer marked last commits it to the slot holding the node id, else the
// lowest free slot, else the slot with the oldest time (lower index on a tie).
// Text beyond MAX_TEXT is dropped; when the first dropped byte is a UTF-8
// continuation byte the kept text is cut back to the last full character.
// Clear frees a slot; lookup returns the stored bytes one per transfer, or a
// single not-found result. Node id zero gives one rejected result. Every
// clear, lookup and final set byte ends with one result marked last_result;
// opcode 3 is dropped with no result.
// A set byte that is not last is only staged in the front part and yields
// nothing. Each other command is queued (two deep) and then run by the back
// part: it is taken from the queue, a set is trimmed one byte at a time if
// needed, the entries are scanned (one slot read per cycle) and the command
// is dispatched. Then a clear, a miss or an empty lookup posts its result; a
// set copies one byte per cycle, writes the slot and posts its result; a
// found lookup reads and then emits each returned byte in turn. A zero node
// id skips the scan and goes straight to its result. Each result waits in
// the output register while rsp.ready is low. The table is empty right after
// reset; there is no clearing pass.
module keyed_alias_table_oldest_evict #(
    parameter int ENTRIES  = kat_pkg::ENTRIES_DEF,
    parameter int MAX_TEXT = kat_pkg::MAX_TEXT_DEF
) (
    input  logic clk,
    input  logic rst_n,
    kat_in_if.sink    cmd,
    kat_out_if.source rsp
);
    import kat_pkg::*;

    // queued command: header, staged count, overflow byte, staged text
    localparam int QW = HDR_W + $clog2(MAX_TEXT + 2) + 8 + 8 * MAX_TEXT;

    logic          push, full, pop, not_empty;
    logic [QW-1:0] push_data, pop_data;

    // classify and stage
    kat_front #(.MAX_TEXT(MAX_TEXT)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    // hold commands so the front keeps taking bytes while the back works
    kat_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_data  (pop_data)
    );

    // scan, commit and answer
    kat_back #(.ENTRIES(ENTRIES), .MAX_TEXT(MAX_TEXT)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (not_empty),
        .q_data  (pop_data),
        .pop     (pop),
        .rsp     (rsp)
    );
endmodule

// ===== dv/kat_alias_checker.sv =====
// Checker for the keyed alias table: watches both channels, predicts results.
// Depends on kat_pkg, kat_in_if, kat_out_if.
module kat_alias_checker #(
    parameter int ENTRIES  = kat_pkg::ENTRIES_DEF,
    parameter int MAX_TEXT = kat_pkg::MAX_TEXT_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    kat_in_if      cmd,
    kat_out_if     rsp,
    output int     fail_count,
    output int     pending
);
    import kat_pkg::*;

    typedef struct packed {
        status_t    status;
        logic [7:0] out_byte;
        logic [4:0] alias_length;
        logic       last_result;
    } alias_result_t;

    logic        slot_used [ENTRIES];
    logic [31:0] slot_key [ENTRIES];
    logic [31:0] slot_stamp [ENTRIES];
    int          slot_len [ENTRIES];
    logic [7:0]  slot_text [ENTRIES][MAX_TEXT];
    logic [7:0]  stage_text [MAX_TEXT];
    int          stage_count;
    logic [7:0]  spill_byte;
    alias_result_t expected_results[$];

    assign pending = expected_results.size();

    function automatic logic cont_byte(input logic [7:0] b);
        return (b & 8'hC0) == 8'h80;
    endfunction

    function automatic int key_slot(input logic [31:0] key);
        for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && slot_key[i] == key) return i;
        return -1;
    endfunction

    function automatic void push_result(input status_t st, input logic [7:0] b,
                                        input int len, input logic lst);
        alias_result_t r;
        r.status = st;
        r.out_byte = b;
        r.alias_length = len[4:0];
        r.last_result = lst;
        expected_results.push_back(r);
    endfunction

    task automatic predict_item(input op_t op, input logic [31:0] key,
                                input logic [7:0] b, input logic lst,
                                input logic [31:0] now);
        int idx;
        int len;
        case (op)
            OP_SET:
            begin
                if (stage_count < MAX_TEXT)
                begin
                    stage_text[stage_count] = b;
                    stage_count++;
                end
                else if (stage_count == MAX_TEXT)
                begin
                    spill_byte = b;
                    stage_count++;
                end
                if (lst)
                begin
                    if (key == 0)
                        push_result(ST_REJECT, 8'h00, 0, 1'b1);
                    else
                    begin
                        len = stage_count;
                        if (len > MAX_TEXT)
                        begin
                            len = MAX_TEXT;
                            if (cont_byte(spill_byte))
                            begin
                                len--;
                                while (len > 0 && cont_byte(stage_text[len])) len--;
                            end
                        end
                        idx = key_slot(key);
                        if (idx < 0)
                        begin
                            for (int i = ENTRIES - 1; i >= 0; i--)
                                if (!slot_used[i]) idx = i;
                            if (idx < 0)
                            begin
                                idx = 0;
                                for (int i = 1; i < ENTRIES; i++)
                                    if (slot_stamp[i] < slot_stamp[idx]) idx = i;
                            end
                        end
                        for (int k = 0; k < len; k++) slot_text[idx][k] = stage_text[k];
                        slot_len[idx] = len;
                        slot_key[idx] = key;
                        slot_used[idx] = 1'b1;
                        slot_stamp[idx] = now;
                        push_result(ST_OK, 8'h00, 0, 1'b1);
                    end
                    stage_count = 0;
                end
            end
            OP_CLEAR:
            begin
                if (key == 0)
                    push_result(ST_REJECT, 8'h00, 0, 1'b1);
                else
                begin
                    idx = key_slot(key);
                    if (idx >= 0)
                    begin
                        slot_used[idx] = 1'b0;
                        slot_key[idx] = 0;
                        slot_stamp[idx] = 0;
                        slot_len[idx] = 0;
                    end
                    push_result(ST_OK, 8'h00, 0, 1'b1);
                end
            end
            OP_LOOKUP:
            begin
                idx = (key == 0) ? -1 : key_slot(key);
                if (key == 0)
                    push_result(ST_REJECT, 8'h00, 0, 1'b1);
                else if (idx < 0)
                    push_result(ST_MISS, 8'h00, 0, 1'b1);
                else if (slot_len[idx] == 0)
                    push_result(ST_OK, 8'h00, 0, 1'b1);
                else
                    for (int k = 0; k < slot_len[idx]; k++)
                        push_result(ST_OK, slot_text[idx][k], slot_len[idx],
                                    k + 1 == slot_len[idx]);
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        alias_result_t got;
        alias_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                slot_used[i] = 1'b0;
                slot_key[i] = 0;
                slot_stamp[i] = 0;
                slot_len[i] = 0;
            end
            stage_count = 0;
            spill_byte = 0;
            fail_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.status = status_t'(rsp.status);
                got.out_byte = rsp.out_byte;
                got.alias_length = rsp.alias_length;
                got.last_result = rsp.last_result;
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got != want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: expected st=%0d b=%h len=%0d last=%0b,",
                                      " got st=%0d b=%h len=%0d last=%0b"},
                                     want.status, want.out_byte, want.alias_length,
                                     want.last_result, got.status, got.out_byte,
                                     got.alias_length, got.last_result);
                    end
                end
            end
            if (cmd.valid && cmd.ready)
                predict_item(op_t'(cmd.opcode), cmd.node_id, cmd.text_byte,
                             cmd.last_byte, cmd.now_time);
        end
    end
endmodule

// ===== dv/keyed_alias_table_oldest_evict_tb.sv =====
// Testbench top for the keyed alias table: clock, reset, stimulus, verdict.
// Depends on kat_pkg, kat_in_if, kat_out_if, kat_alias_checker and the block.
module keyed_alias_table_oldest_evict_tb;
    import kat_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   stall_cycles;
    bit   sink_busy;

    kat_in_if  cmd ();
    kat_out_if rsp ();

    keyed_alias_table_oldest_evict u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    kat_alias_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #1 clk = ~clk;

    // Short gaps mostly, an occasional long one.
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 1);
        if ($urandom_range(0, 3) != 0) return $urandom_range(2, 5);
        return $urandom_range(10, 40);
    endfunction

    // Receiver side: stall randomly, with quiet stretches where ready stays high.
    initial
    begin
        int n;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (sink_busy)
            begin
                n = gap_len();
                rsp.ready <= (n == 0);
                repeat (n + 1) @(posedge clk);
                rsp.ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                rsp.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Count cycles without any transfer; end the run when stuck.
    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Present one item, hold it until it is transferred, then maybe idle.
    task automatic send_item(input op_t op, input logic [31:0] key,
                             input logic [7:0] b, input logic lst,
                             input logic [31:0] now);
        int n;
        cmd.valid     <= 1'b1;
        cmd.opcode    <= op;
        cmd.node_id   <= key;
        cmd.text_byte <= b;
        cmd.last_byte <= lst;
        cmd.now_time  <= now;
        @(posedge clk);
        while (!cmd.ready) @(posedge clk);
        n = gap_len();
        if (n > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Stream a whole set: len bytes, the last one carrying key and time.
    task automatic send_text(input logic [31:0] key, input int len,
                             input logic [31:0] now, input int flavor);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            case (flavor)
                0: b = 8'($urandom_range(0, 255));
                1: b = 8'h80 | 8'($urandom_range(0, 63));
                default: b = (i % 3 == 0) ? (8'hC0 | 8'($urandom_range(0, 63)))
                                          : (8'h80 | 8'($urandom_range(0, 63)));
            endcase
            send_item(OP_SET, (i == len - 1) ? key : $urandom, b, i == len - 1, now);
        end
    endtask

    // Small key pool so keys hit often; zero appears now and then.
    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return 32'h0;
        if (r < 8) return $urandom;
        if (r < 10) return 32'hFFFF_FFFF;
        return $urandom_range(1, 24);
    endfunction

    initial
    begin
        int sent;
        int r;
        bit paused;
        logic [31:0] clock_ms;
        cmd.valid     <= 1'b0;
        cmd.opcode    <= OP_SET;
        cmd.node_id   <= '0;
        cmd.text_byte <= '0;
        cmd.last_byte <= 1'b0;
        cmd.now_time  <= '0;
        sink_busy = 1'b0;
        paused = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: extremes, every opcode, trim and reject cases.
        send_text(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0);
        send_item(OP_LOOKUP, 32'hFFFF_FFFF, 8'h00, 1'b0, 0);
        send_item(OP_SET, 32'h0, 8'hFF, 1'b1, 0);
        send_item(OP_CLEAR, 32'h0, 8'h00, 1'b1, 0);
        send_item(OP_LOOKUP, 32'h0, 8'h00, 1'b0, 0);
        send_item(OP_LOOKUP, 32'h1234_5678, 8'h00, 1'b0, 0);
        send_item(OP_NONE, 32'h5, 8'hAA, 1'b1, 0);
        send_text(32'h5, 17, 32'h10, 1);    // all continuation: trims to empty
        send_item(OP_LOOKUP, 32'h5, 8'h00, 1'b0, 0);
        send_text(32'h6, 20, 32'h20, 2);    // mixed lead bytes: trim to a lead
        send_item(OP_LOOKUP, 32'h6, 8'h00, 1'b0, 0);
        send_text(32'h7, 16, 32'h0, 1);     // exact fit never trimmed
        send_item(OP_LOOKUP, 32'h7, 8'h00, 1'b0, 0);
        send_item(OP_CLEAR, 32'h7, 8'h00, 1'b0, 0);
        send_item(OP_CLEAR, 32'h7, 8'h00, 1'b0, 0);
        send_item(OP_LOOKUP, 32'h7, 8'h00, 1'b0, 0);
        sent = 66;

        // Drain before random traffic starts.
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        sink_busy = 1'b1;

        // Random part: mostly full set streams on a small key pool.
        clock_ms = $urandom_range(0, 1000);
        while (sent < 270)
        begin
            r = $urandom_range(0, 99);
            clock_ms = ($urandom_range(0, 9) == 0) ? $urandom : clock_ms + $urandom_range(0, 3);
            if (r < 40)
            begin
                int len;
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 22)
                                                  : $urandom_range(1, 8);
                send_text(pick_key(), len, clock_ms, $urandom_range(0, 2));
                sent += len;
            end
            else if (r < 55)
            begin
                // Interleave a command inside a set stream.
                send_item(OP_SET, $urandom, 8'($urandom), 1'b0, clock_ms);
                send_item(op_t'($urandom_range(1, 2)), pick_key(), 8'($urandom), 1'b0,
                          clock_ms);
                send_item(OP_SET, pick_key(), 8'($urandom), 1'b1, clock_ms);
                sent += 3;
            end
            else if (r < 65)
            begin
                send_item(OP_CLEAR, pick_key(), 8'($urandom), 1'($urandom), clock_ms);
                sent++;
            end
            else if (r < 95)
            begin
                send_item(OP_LOOKUP, pick_key(), 8'($urandom), 1'($urandom), $urandom);
                sent++;
            end
            else
            begin
                send_item(OP_NONE, $urandom, 8'($urandom), 1'($urandom), $urandom);
                sent++;
            end
            if (!paused && sent > 130)
            begin
                // Hold off until all results are back.
                paused = 1'b1;
                cmd.valid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
        end
        cmd.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
